FILE: sv/cfmb_pkg.sv
// ============================================================================
// cfmb_pkg
// shared types and constants of the constituent four-momentum builder
// ============================================================================
`default_nettype none

package cfmb_pkg;

    localparam int PT_W  = 16;
    localparam int ETA_W = 16;
    localparam int PHI_W = 15;
    localparam int POS_W = 12;
    localparam int PXY_W = 17;
    localparam int PZ_W  = 24;
    localparam int E_W   = 23;
    localparam int MAG_W = 16;

    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 16;
    localparam logic [CFG_INDEX_W-1:0] REG_USER_MIN_PT  = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_GHOST_MIN_PT = 4'd1;

    // series arithmetic
    localparam int Q30_SHIFT  = 30;
    localparam int FRAC_SHIFT = 12;
    localparam int TERM_W     = 39;
    localparam int ACC_W      = 44;
    localparam int K_W        = 6;
    localparam int EXP_TERMS  = 40;
    localparam int TRIG_TERMS = 30;
    localparam int STEP_LAT   = 3;

    // reciprocal
    localparam int RECIP_SHIFT = 60;
    localparam int EP_W        = 42;
    localparam int EN_W        = 31;
    localparam int CS_W        = 43;
    localparam int Q_W         = 37;

    localparam logic [PXY_W-2:0] PXY_MAX = 16'hFFFF;
    localparam logic [E_W-1:0]   PZE_MAX = 23'h7FFFFF;

    localparam int QUEUE_DEPTH = 4;

    // accumulator routing of one series term
    localparam int ACC_A_ADD = 0;
    localparam int ACC_B_ADD = 1;
    localparam int ACC_A_SUB = 2;
    localparam int ACC_B_SUB = 3;

    typedef struct packed {
        logic             kept;
        logic             ghost;
        logic [POS_W-1:0] position;
        logic [PT_W-1:0]  orig_pt;
        logic [PT_W-1:0]  pe;
        logic [MAG_W-1:0] emag;
        logic             eneg;
        logic [PHI_W-1:0] pmag;
        logic             pneg;
        logic             last;
    } item_t;

endpackage

`default_nettype wire

FILE: sv/cfmb_front.sv
// ============================================================================
// cfmb_front
// configuration registers, per-event index counter and item classification
// ============================================================================
`default_nettype none

module cfmb_front
    import cfmb_pkg::*;
#(
    parameter int MAX_CONSTITUENTS = 4096
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   push,
    input  wire logic                   q_full,
    input  wire logic [PT_W-1:0]        pt,
    input  wire logic signed [ETA_W-1:0] eta,
    input  wire logic signed [PHI_W-1:0] phi,
    input  wire logic                   id_ok,
    input  wire logic                   last_in_event,
    input  wire logic                   cfg_write,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    output logic                        q_wr,
    output item_t                       item
);

    localparam int TOP_INT = (MAX_CONSTITUENTS - 1 < 4095) ? MAX_CONSTITUENTS - 1 : 4095;
    localparam logic [POS_W-1:0] CNT_TOP = POS_W'(TOP_INT);

    logic [PT_W-1:0]  user_min_pt_reg;
    logic [PT_W-1:0]  ghost_min_pt_reg;
    logic [POS_W-1:0] cnt_reg;
    logic [POS_W-1:0] cnt_next;
    logic [ETA_W-1:0] eta_u;
    logic [PHI_W-1:0] phi_u;
    logic             below_user;

    always_comb
    begin
        eta_u      = $unsigned(eta);
        phi_u      = $unsigned(phi);
        q_wr       = push && !q_full;
        below_user = (user_min_pt_reg != '0) && (pt < user_min_pt_reg);

        item.kept     = id_ok && !below_user;
        item.ghost    = item.kept && (pt < ghost_min_pt_reg);
        item.position = id_ok ? cnt_reg : '0;
        item.orig_pt  = id_ok ? pt : '0;
        item.pe       = item.ghost ? ghost_min_pt_reg : pt;
        item.eneg     = eta_u[ETA_W-1];
        item.emag     = eta_u[ETA_W-1] ? (~eta_u + 1'b1) : eta_u;
        item.pneg     = phi_u[PHI_W-1];
        item.pmag     = phi_u[PHI_W-1] ? (~phi_u + 1'b1) : phi_u;
        item.last     = last_in_event;

        cnt_next = cnt_reg;
        if (q_wr)
        begin
            if (last_in_event)
            begin
                cnt_next = '0;
            end
            else if (id_ok && (cnt_reg < CNT_TOP))
            begin
                cnt_next = cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg          <= '0;
            user_min_pt_reg  <= '0;
            ghost_min_pt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_USER_MIN_PT:  user_min_pt_reg  <= cfg_data;
                    REG_GHOST_MIN_PT: ghost_min_pt_reg <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_TOP)
        else $error("index counter above its top");

    a_cnt_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (q_wr && last_in_event) |=> (cnt_reg == '0))
        else $error("index counter not cleared after end of event");

    a_cnt_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (q_wr && !id_ok && !last_in_event) |=> $stable(cnt_reg))
        else $error("index counter moved on an unidentified request");

endmodule

`default_nettype wire

FILE: sv/cfmb_queue.sv
// ============================================================================
// cfmb_queue
// short queue of classified requests between front and back
// ============================================================================
`default_nettype none

module cfmb_queue
    import cfmb_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  wr,
    input  item_t      wr_item,
    output logic       full,
    input  wire logic  rd,
    output item_t      rd_item,
    output logic       empty
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    item_t            entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W:0]   count_reg;

    assign full    = (count_reg == (PTR_W+1)'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign rd_item = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            entry_reg[wr_ptr_reg] <= wr_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (rd)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (wr && !rd)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (rd && !wr)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (PTR_W+1)'(QUEUE_DEPTH))
        else $error("queue count above depth");

endmodule

`default_nettype wire

FILE: sv/cfmb_step.sv
// ============================================================================
// cfmb_step
// one series term: term * mag / (4096 * K), floored, added to or subtracted from an accumulator
// ============================================================================
`default_nettype none

module cfmb_step
    import cfmb_pkg::*;
#(
    parameter int K     = 1,
    parameter int ROUTE = ACC_A_ADD
)
(
    input  wire logic                    clk,
    input  wire logic                    en,
    input  wire logic [TERM_W-1:0]       term_i,
    input  wire logic [MAG_W-1:0]        mag_i,
    input  wire logic signed [ACC_W-1:0] acc_a_i,
    input  wire logic signed [ACC_W-1:0] acc_b_i,
    output logic [TERM_W-1:0]            term_o,
    output logic [MAG_W-1:0]             mag_o,
    output logic signed [ACC_W-1:0]      acc_a_o,
    output logic signed [ACC_W-1:0]      acc_b_o
);

    localparam int PROD_W = TERM_W + MAG_W;
    localparam int XW     = PROD_W - FRAC_SHIFT;
    localparam int XL_W   = 22;
    localparam int XH_W   = XW - XL_W;
    localparam int YW     = K_W + XL_W;
    localparam logic [K_W-1:0]  KC = K_W'(K);
    localparam logic [XH_W+1:0] MH = (XH_W+2)'((64'd1 << XH_W) / K);
    localparam logic [YW:0]     ML = (YW+1)'((64'd1 << YW) / K);

    logic [PROD_W-1:0]       prod_reg;
    logic [MAG_W-1:0]        mag1_reg;
    logic signed [ACC_W-1:0] a1_reg;
    logic signed [ACC_W-1:0] b1_reg;

    logic [XH_W-1:0]         qh_reg;
    logic [K_W-1:0]          rh_reg;
    logic [XL_W-1:0]         xl_reg;
    logic [MAG_W-1:0]        mag2_reg;
    logic signed [ACC_W-1:0] a2_reg;
    logic signed [ACC_W-1:0] b2_reg;

    logic [XW-1:0]           x;
    logic [XH_W-1:0]         xh;
    logic [2*XH_W+1:0]       hprod;
    logic [XH_W-1:0]         qh0;
    logic [XH_W+K_W-1:0]     qk;
    logic [XH_W-1:0]         rh0;
    logic [XH_W-1:0]         qh;
    logic [K_W-1:0]          rh;

    logic [YW-1:0]           y;
    logic [2*YW:0]           lprod;
    logic [YW-1:0]           ql0;
    logic [YW+K_W-1:0]       lk;
    logic [YW-1:0]           rl0;
    logic [YW-1:0]           ql;
    logic [TERM_W-1:0]       term;
    logic signed [ACC_W-1:0] term_s;
    logic signed [ACC_W-1:0] a_next;
    logic signed [ACC_W-1:0] b_next;

    always_comb
    begin
        x     = prod_reg[PROD_W-1:FRAC_SHIFT];
        xh    = x[XW-1:XL_W];
        hprod = xh * MH;
        qh0   = hprod[XH_W +: XH_W];
        qk    = qh0 * KC;
        rh0   = xh - XH_W'(qk);
        if (rh0 >= XH_W'(KC))
        begin
            qh = qh0 + 1'b1;
            rh = K_W'(rh0 - XH_W'(KC));
        end
        else
        begin
            qh = qh0;
            rh = K_W'(rh0);
        end

        y     = {rh_reg, xl_reg};
        lprod = y * ML;
        ql0   = lprod[YW +: YW];
        lk    = ql0 * KC;
        rl0   = y - YW'(lk);
        ql    = (rl0 >= YW'(KC)) ? ql0 + 1'b1 : ql0;
        term  = TERM_W'({qh_reg, ql[XL_W-1:0]});
        term_s = $signed({{(ACC_W-TERM_W){1'b0}}, term});

        a_next = a2_reg;
        b_next = b2_reg;
        case (ROUTE)
            ACC_A_ADD: a_next = a2_reg + term_s;
            ACC_B_ADD: b_next = b2_reg + term_s;
            ACC_A_SUB: a_next = a2_reg - term_s;
            ACC_B_SUB: b_next = b2_reg - term_s;
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= term_i * mag_i;
            mag1_reg <= mag_i;
            a1_reg   <= acc_a_i;
            b1_reg   <= acc_b_i;

            qh_reg   <= qh;
            rh_reg   <= rh;
            xl_reg   <= x[XL_W-1:0];
            mag2_reg <= mag1_reg;
            a2_reg   <= a1_reg;
            b2_reg   <= b1_reg;

            term_o   <= term;
            mag_o    <= mag2_reg;
            acc_a_o  <= a_next;
            acc_b_o  <= b_next;
        end
    end

endmodule

`default_nettype wire

FILE: sv/cfmb_recip.sv
// ============================================================================
// cfmb_recip
// pipelined restoring divider: round(2^60 / ep), one quotient bit per stage
// ============================================================================
`default_nettype none

module cfmb_recip
    import cfmb_pkg::*;
(
    input  wire logic            clk,
    input  wire logic            en,
    input  wire logic [EP_W-1:0] ep_i,
    output logic [EP_W-1:0]      ep_o,
    output logic [EN_W-1:0]      quot_o
);

    localparam int STEPS = EN_W;

    logic [EP_W-1:0] rem_s [STEPS+1];
    logic [EP_W-1:0] ep_s  [STEPS+1];
    logic [EN_W-1:0] nl_s  [STEPS+1];
    logic [EN_W-1:0] q_s   [STEPS+1];

    // numerator 2^60 + ep/2, upper part preloaded below the divisor
    always_comb
    begin
        rem_s[0] = EP_W'(64'd1 << (RECIP_SHIFT - STEPS)) + EP_W'(ep_i >> (STEPS + 1));
        ep_s[0]  = ep_i;
        nl_s[0]  = ep_i[STEPS:1];
        q_s[0]   = '0;
    end

    for (genvar j = 0; j < STEPS; j++)
    begin : g_div
        logic [EP_W:0] r;
        logic          ge;

        always_comb
        begin
            r  = {rem_s[j], nl_s[j][STEPS-1-j]};
            ge = (r >= {1'b0, ep_s[j]});
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_s[j+1] <= ge ? EP_W'(r - {1'b0, ep_s[j]}) : EP_W'(r);
                ep_s[j+1]  <= ep_s[j];
                nl_s[j+1]  <= nl_s[j];
                q_s[j+1]   <= {q_s[j][EN_W-2:0], ge};
            end
        end
    end

    assign ep_o   = ep_s[STEPS];
    assign quot_o = q_s[STEPS];

endmodule

`default_nettype wire

FILE: sv/cfmb_back.sv
// ============================================================================
// cfmb_back
// series pipelines, reciprocal and final scaling into the result register
// ============================================================================
`default_nettype none

module cfmb_back
    import cfmb_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              q_empty,
    input  item_t                  q_item,
    output logic                   q_rd,
    input  wire logic              pop,
    output logic                   empty,
    output logic                   kept,
    output logic                   ghost,
    output logic [POS_W-1:0]       position,
    output logic [PT_W-1:0]        orig_pt,
    output logic signed [PXY_W-1:0] px,
    output logic signed [PXY_W-1:0] py,
    output logic signed [PZ_W-1:0] pz,
    output logic [E_W-1:0]         energy,
    output logic                   event_end
);

    localparam int EXP_LAT  = EXP_TERMS * STEP_LAT;
    localparam int TRIG_LAT = TRIG_TERMS * STEP_LAT;
    localparam int TRIG_DLY = EXP_LAT + EN_W - TRIG_LAT;
    localparam int PAY_LEN  = EXP_LAT + EN_W + 1;
    localparam logic [TERM_W-1:0] TERM_ONE = TERM_W'(64'd1 << Q30_SHIFT);
    localparam logic signed [ACC_W-1:0] ACC_ONE = ACC_W'(64'd1 << Q30_SHIFT);

    logic adv;
    logic v_reg [PAY_LEN+1];
    item_t pay_reg [PAY_LEN];

    logic [TERM_W-1:0]       e_term [EXP_TERMS+1];
    logic [MAG_W-1:0]        e_mag  [EXP_TERMS+1];
    logic signed [ACC_W-1:0] e_a    [EXP_TERMS+1];
    logic signed [ACC_W-1:0] e_b    [EXP_TERMS+1];
    logic [TERM_W-1:0]       t_term [TRIG_TERMS+1];
    logic [MAG_W-1:0]        t_mag  [TRIG_TERMS+1];
    logic signed [ACC_W-1:0] t_a    [TRIG_TERMS+1];
    logic signed [ACC_W-1:0] t_b    [TRIG_TERMS+1];

    logic signed [ACC_W-1:0] c_dly_reg [TRIG_DLY];
    logic signed [ACC_W-1:0] s_dly_reg [TRIG_DLY];

    logic [EP_W-1:0] ep_d;
    logic [EN_W-1:0] en_d;

    logic [PT_W+CS_W-1:0]   prod_e_reg;
    logic [PT_W+EP_W-1:0]   prod_z_reg;
    logic [PT_W+Q_W-1:0]    prod_x_reg;
    logic [PT_W+Q_W-1:0]    prod_y_reg;
    logic                   cneg_reg;
    logic                   sneg_reg;

    logic [CS_W-1:0]        cs;
    logic [EP_W-1:0]        sn;
    logic signed [ACC_W-1:0] c_val;
    logic signed [ACC_W-1:0] s_val;
    logic [ACC_W-1:0]       c_abs;
    logic [ACC_W-1:0]       s_abs;

    logic [PT_W+CS_W:0]     e_round;
    logic [PT_W+EP_W:0]     z_round;
    logic [PT_W+Q_W:0]      x_round;
    logic [PT_W+Q_W:0]      y_round;
    logic [E_W-1:0]         e_sat;
    logic [E_W-1:0]         z_sat;
    logic [PXY_W-2:0]       x_sat;
    logic [PXY_W-2:0]       y_sat;
    item_t                  fin;

    assign adv   = !v_reg[PAY_LEN] || pop;
    assign q_rd  = adv && !q_empty;
    assign empty = !v_reg[PAY_LEN];

    // exp(|eta|) series
    assign e_term[0] = TERM_ONE;
    assign e_mag[0]  = q_item.emag;
    assign e_a[0]    = ACC_ONE;
    assign e_b[0]    = '0;

    for (genvar k = 1; k <= EXP_TERMS; k++)
    begin : g_exp
        cfmb_step #(.K(k), .ROUTE(ACC_A_ADD)) u_step
        (
            .clk     (clk),
            .en      (adv),
            .term_i  (e_term[k-1]),
            .mag_i   (e_mag[k-1]),
            .acc_a_i (e_a[k-1]),
            .acc_b_i (e_b[k-1]),
            .term_o  (e_term[k]),
            .mag_o   (e_mag[k]),
            .acc_a_o (e_a[k]),
            .acc_b_o (e_b[k])
        );
    end

    // cos and sin of |phi|
    assign t_term[0] = TERM_ONE;
    assign t_mag[0]  = {1'b0, q_item.pmag};
    assign t_a[0]    = ACC_ONE;
    assign t_b[0]    = '0;

    for (genvar k = 1; k <= TRIG_TERMS; k++)
    begin : g_trig
        cfmb_step #(.K(k), .ROUTE(k % 4)) u_step
        (
            .clk     (clk),
            .en      (adv),
            .term_i  (t_term[k-1]),
            .mag_i   (t_mag[k-1]),
            .acc_a_i (t_a[k-1]),
            .acc_b_i (t_b[k-1]),
            .term_o  (t_term[k]),
            .mag_o   (t_mag[k]),
            .acc_a_o (t_a[k]),
            .acc_b_o (t_b[k])
        );
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            c_dly_reg[0] <= t_a[TRIG_TERMS];
            s_dly_reg[0] <= t_b[TRIG_TERMS];
            for (int i = 1; i < TRIG_DLY; i++)
            begin
                c_dly_reg[i] <= c_dly_reg[i-1];
                s_dly_reg[i] <= s_dly_reg[i-1];
            end
        end
    end

    cfmb_recip u_recip
    (
        .clk    (clk),
        .en     (adv),
        .ep_i   (EP_W'($unsigned(e_a[EXP_TERMS]))),
        .ep_o   (ep_d),
        .quot_o (en_d)
    );

    // scaling
    always_comb
    begin
        cs    = {1'b0, ep_d} + CS_W'(en_d);
        sn    = ep_d - EP_W'(en_d);
        c_val = c_dly_reg[TRIG_DLY-1];
        s_val = s_dly_reg[TRIG_DLY-1];
        c_abs = c_val[ACC_W-1] ? $unsigned(-c_val) : $unsigned(c_val);
        s_abs = s_val[ACC_W-1] ? $unsigned(-s_val) : $unsigned(s_val);

        fin     = pay_reg[PAY_LEN-1];
        e_round = {1'b0, prod_e_reg} + (PT_W+CS_W+1)'(64'd1 << Q30_SHIFT);
        z_round = {1'b0, prod_z_reg} + (PT_W+EP_W+1)'(64'd1 << Q30_SHIFT);
        x_round = {1'b0, prod_x_reg} + (PT_W+Q_W+1)'(64'd1 << (Q30_SHIFT - 1));
        y_round = {1'b0, prod_y_reg} + (PT_W+Q_W+1)'(64'd1 << (Q30_SHIFT - 1));

        e_sat = ((e_round >> (Q30_SHIFT + 1)) > (PT_W+CS_W+1)'(PZE_MAX)) ? PZE_MAX
              : E_W'(e_round >> (Q30_SHIFT + 1));
        z_sat = ((z_round >> (Q30_SHIFT + 1)) > (PT_W+EP_W+1)'(PZE_MAX)) ? PZE_MAX
              : E_W'(z_round >> (Q30_SHIFT + 1));
        x_sat = ((x_round >> Q30_SHIFT) > (PT_W+Q_W+1)'(PXY_MAX)) ? PXY_MAX
              : (PXY_W-1)'(x_round >> Q30_SHIFT);
        y_sat = ((y_round >> Q30_SHIFT) > (PT_W+Q_W+1)'(PXY_MAX)) ? PXY_MAX
              : (PXY_W-1)'(y_round >> Q30_SHIFT);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pay_reg[0] <= q_item;
            for (int i = 1; i < PAY_LEN; i++)
            begin
                pay_reg[i] <= pay_reg[i-1];
            end

            prod_e_reg <= pay_reg[PAY_LEN-2].pe * cs;
            prod_z_reg <= pay_reg[PAY_LEN-2].pe * sn;
            prod_x_reg <= pay_reg[PAY_LEN-2].pe * Q_W'(c_abs);
            prod_y_reg <= pay_reg[PAY_LEN-2].pe * Q_W'(s_abs);
            cneg_reg   <= c_val[ACC_W-1];
            sneg_reg   <= s_val[ACC_W-1];

            kept      <= fin.kept;
            ghost     <= fin.kept && fin.ghost;
            position  <= fin.position;
            orig_pt   <= fin.orig_pt;
            event_end <= fin.last;
            if (fin.kept)
            begin
                energy <= e_sat;
                pz     <= fin.eneg ? -$signed({1'b0, z_sat}) : $signed({1'b0, z_sat});
                px     <= cneg_reg ? -$signed({1'b0, x_sat}) : $signed({1'b0, x_sat});
                py     <= (sneg_reg != fin.pneg) ? -$signed({1'b0, y_sat})
                                                 : $signed({1'b0, y_sat});
            end
            else
            begin
                energy <= '0;
                pz     <= '0;
                px     <= '0;
                py     <= '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= PAY_LEN; i++)
            begin
                v_reg[i] <= 1'b0;
            end
        end
        else if (adv)
        begin
            v_reg[0] <= !q_empty;
            for (int i = 1; i <= PAY_LEN; i++)
            begin
                v_reg[i] <= v_reg[i-1];
            end
        end
    end

endmodule

`default_nettype wire

FILE: sv/constituent_four_momentum_builder.sv
// ============================================================================
// constituent_four_momentum_builder
// massless four-momentum from pt, eta and phi of particle constituents
// ============================================================================
// throughput: one request per cycle sustained while no finished result waits unpopped
// the path from request to result runs through the 40-term exp series and the
// 31-stage reciprocal divider that follows it
// a waiting result holds the whole back pipeline; the 4-entry queue keeps taking
// reset: asynchronous, clears index counter, config registers, queue, valid bits
`default_nettype none

module constituent_four_momentum_builder
    import cfmb_pkg::*;
#(
    parameter int MAX_CONSTITUENTS = 4096
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    push,
    output logic                         full,
    input  wire logic [PT_W-1:0]         pt,
    input  wire logic signed [ETA_W-1:0] eta,
    input  wire logic signed [PHI_W-1:0] phi,
    input  wire logic                    id_ok,
    input  wire logic                    last_in_event,
    input  wire logic                    cfg_write,
    input  wire logic [CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0]   cfg_data,
    output logic                         empty,
    input  wire logic                    pop,
    output logic                         kept,
    output logic                         ghost,
    output logic [POS_W-1:0]             position,
    output logic [PT_W-1:0]              orig_pt,
    output logic signed [PXY_W-1:0]      px,
    output logic signed [PXY_W-1:0]      py,
    output logic signed [PZ_W-1:0]       pz,
    output logic [E_W-1:0]               energy,
    output logic                         event_end
);

    logic  q_wr;
    logic  q_rd;
    logic  q_empty;
    item_t wr_item;
    item_t rd_item;

    cfmb_front #(.MAX_CONSTITUENTS(MAX_CONSTITUENTS)) u_front
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .q_full        (full),
        .pt            (pt),
        .eta           (eta),
        .phi           (phi),
        .id_ok         (id_ok),
        .last_in_event (last_in_event),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .q_wr          (q_wr),
        .item          (wr_item)
    );

    cfmb_queue u_queue
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (q_wr),
        .wr_item (wr_item),
        .full    (full),
        .rd      (q_rd),
        .rd_item (rd_item),
        .empty   (q_empty)
    );

    cfmb_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_item    (rd_item),
        .q_rd      (q_rd),
        .pop       (pop),
        .empty     (empty),
        .kept      (kept),
        .ghost     (ghost),
        .position  (position),
        .orig_pt   (orig_pt),
        .px        (px),
        .py        (py),
        .pz        (pz),
        .energy    (energy),
        .event_end (event_end)
    );

endmodule

`default_nettype wire
